// ----- src/ipag_pkg.sv -----
package ipag_pkg;

    localparam int CFG_DIM_W   = 13;
    localparam int CFG_KER_W   = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam int TAP_W       = 3;
    localparam int BASE_W      = 22;
    localparam int SRC_W       = 44;
    localparam int DST_W       = 50;
    localparam int COL_STEP_W  = 21;
    localparam int ROW_STEP_W  = 34;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IN_HEIGHT     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IN_WIDTH      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_HEIGHT = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_WIDTH  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE_PAIR   = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DILATION_PAIR = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_PADDING_PAIR  = 4'd7;

    typedef struct packed {
        logic [7:0]  batch_index;
        logic [11:0] out_row;
        logic [11:0] out_col;
        logic [31:0] out_pixel;
    } in_item_t;

    typedef struct packed {
        logic [43:0] src_address;
        logic [49:0] dst_address;
        logic        is_padding;
        logic        last_tap;
    } out_item_t;

    // Configuration after range clamping
    typedef struct packed {
        logic [CFG_DIM_W-1:0] in_height;
        logic [CFG_DIM_W-1:0] in_width;
        logic [CFG_DIM_W-1:0] channels;
        logic [CFG_KER_W-1:0] kernel_height;
        logic [CFG_KER_W-1:0] kernel_width;
        logic [7:0]           stride_row;
        logic [7:0]           stride_col;
        logic [7:0]           rate_row;
        logic [7:0]           rate_col;
        logic [7:0]           pad_top;
        logic [7:0]           pad_left;
    } cfg_t;

    // Per-pixel work handed from front to back
    typedef struct packed {
        logic [SRC_W-1:0]      src_base;
        logic [DST_W-1:0]      dst_base;
        logic [BASE_W-1:0]     row_base;
        logic [BASE_W-1:0]     col_base;
        logic [ROW_STEP_W-1:0] row_step;
        logic [COL_STEP_W-1:0] col_step;
    } desc_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_BASE,
        FR_SCALE,
        FR_ROW,
        FR_COL,
        FR_ADDR,
        FR_PUSH
    } front_state_t;

endpackage

// ----- src/ipag_front.sv -----
module ipag_front (
    input  logic               clk,
    input  logic               rst_n,
    input  ipag_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  ipag_pkg::in_item_t in_data,
    output logic               push,
    output ipag_pkg::desc_t    push_data,
    input  logic               full
);

    ipag_pkg::front_state_t state_reg, state_next;

    ipag_pkg::in_item_t                    item_reg;
    logic [ipag_pkg::BASE_W-1:0]           row_base_reg;
    logic [ipag_pkg::BASE_W-1:0]           col_base_reg;
    logic [20:0]                           bh_reg;
    logic [6:0]                            taps_reg;
    logic [ipag_pkg::COL_STEP_W-1:0]       col_step_reg;
    logic [20:0]                           rw_reg;
    logic [ipag_pkg::SRC_W-1:0]            rowpix_reg;
    logic [19:0]                           oc_reg;
    logic [ipag_pkg::ROW_STEP_W-1:0]       row_step_reg;
    logic [ipag_pkg::SRC_W-1:0]            t_reg;
    logic [ipag_pkg::DST_W-1:0]            dst_base_reg;
    logic [ipag_pkg::SRC_W-1:0]            pix_reg;
    logic [ipag_pkg::SRC_W-1:0]            src_base_reg;

    logic [19:0]                           row_prod;
    logic [19:0]                           col_prod;
    logic [20:0]                           bh_prod;
    logic [7:0]                            taps_prod;
    logic [ipag_pkg::COL_STEP_W-1:0]       col_step_prod;
    logic [20:0]                           rw_prod;
    logic [19:0]                           oc_prod;
    logic [ipag_pkg::ROW_STEP_W-1:0]       row_step_prod;
    logic [ipag_pkg::SRC_W-1:0]            t_prod;
    logic [51:0]                           dst_prod;
    logic [ipag_pkg::SRC_W-1:0]            src_prod;

    assign row_prod      = item_reg.out_row * cfg.stride_row;
    assign col_prod      = item_reg.out_col * cfg.stride_col;
    assign bh_prod       = item_reg.batch_index * cfg.in_height;
    assign taps_prod     = cfg.kernel_height * cfg.kernel_width;
    assign col_step_prod = cfg.rate_col * cfg.channels;
    assign rw_prod       = cfg.rate_row * cfg.in_width;
    assign oc_prod       = taps_reg * cfg.channels;
    assign row_step_prod = rw_reg * cfg.channels;
    // Address products wrap at the field width
    assign t_prod        = rowpix_reg * cfg.in_width;
    assign dst_prod      = item_reg.out_pixel * oc_reg;
    assign src_prod      = pix_reg * cfg.channels;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipag_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            ipag_pkg::FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ipag_pkg::FR_BASE;
                end
            end
            ipag_pkg::FR_BASE:  state_next = ipag_pkg::FR_SCALE;
            ipag_pkg::FR_SCALE: state_next = ipag_pkg::FR_ROW;
            ipag_pkg::FR_ROW:   state_next = ipag_pkg::FR_COL;
            ipag_pkg::FR_COL:   state_next = ipag_pkg::FR_ADDR;
            ipag_pkg::FR_ADDR:  state_next = ipag_pkg::FR_PUSH;
            ipag_pkg::FR_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = ipag_pkg::FR_IDLE;
                end
            end
            default: state_next = ipag_pkg::FR_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ipag_pkg::FR_IDLE:
            begin
                if (in_valid)
                begin
                    item_reg <= in_data;
                end
            end
            ipag_pkg::FR_BASE:
            begin
                // bases may go negative by up to the padding
                row_base_reg <= {2'b00, row_prod} - {14'b0, cfg.pad_top};
                col_base_reg <= {2'b00, col_prod} - {14'b0, cfg.pad_left};
                bh_reg       <= bh_prod;
                taps_reg     <= taps_prod[6:0];
                col_step_reg <= col_step_prod;
                rw_reg       <= rw_prod;
            end
            ipag_pkg::FR_SCALE:
            begin
                rowpix_reg   <= {23'b0, bh_reg}
                              + {{22{row_base_reg[ipag_pkg::BASE_W-1]}}, row_base_reg};
                oc_reg       <= oc_prod;
                row_step_reg <= row_step_prod;
            end
            ipag_pkg::FR_ROW:
            begin
                t_reg        <= t_prod;
                dst_base_reg <= dst_prod[ipag_pkg::DST_W-1:0];
            end
            ipag_pkg::FR_COL:
            begin
                pix_reg <= t_reg
                         + {{22{col_base_reg[ipag_pkg::BASE_W-1]}}, col_base_reg};
            end
            ipag_pkg::FR_ADDR:
            begin
                src_base_reg <= src_prod;
            end
            ipag_pkg::FR_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        push_data.src_base = src_base_reg;
        push_data.dst_base = dst_base_reg;
        push_data.row_base = row_base_reg;
        push_data.col_base = col_base_reg;
        push_data.row_step = row_step_reg;
        push_data.col_step = col_step_reg;
    end

endmodule

// ----- src/ipag_queue.sv -----
module ipag_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ipag_pkg::desc_t push_data,
    output logic            full,
    input  logic            pop,
    output ipag_pkg::desc_t pop_data,
    output logic            empty
);

    localparam int PTR_W = (ipag_pkg::QUEUE_DEPTH > 1) ? $clog2(ipag_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ipag_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(ipag_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ipag_pkg::QUEUE_DEPTH);

    ipag_pkg::desc_t  slot_reg [ipag_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/ipag_back.sv -----
module ipag_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ipag_pkg::cfg_t      cfg,
    input  logic                empty,
    input  ipag_pkg::desc_t     pop_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output ipag_pkg::out_item_t out_data
);

    logic                           busy_reg;
    logic [ipag_pkg::TAP_W-1:0]     tap_row_reg, tap_col_reg;
    ipag_pkg::desc_t                desc_reg;
    logic [ipag_pkg::BASE_W-1:0]    ih_reg, iw_reg;
    logic [ipag_pkg::SRC_W-1:0]     row_addr_reg, addr_reg;
    logic [ipag_pkg::DST_W-1:0]     dst_reg;
    logic                           out_valid_reg;
    ipag_pkg::out_item_t            out_data_reg;

    logic [ipag_pkg::TAP_W-1:0]     kh_m1, kw_m1;
    logic                           emit, last, pad, row_end;
    logic [ipag_pkg::SRC_W-1:0]     next_row_addr;

    assign kh_m1 = ipag_pkg::TAP_W'(cfg.kernel_height - 1'b1);
    assign kw_m1 = ipag_pkg::TAP_W'(cfg.kernel_width - 1'b1);

    assign emit    = busy_reg && (!out_valid_reg || out_ready);
    assign row_end = (tap_col_reg == kw_m1);
    assign last    = row_end && (tap_row_reg == kh_m1);
    assign pop     = !empty && (!busy_reg || (emit && last));

    // negative coordinates have the top bit set
    assign pad = ih_reg[ipag_pkg::BASE_W-1]
              || (ih_reg[ipag_pkg::BASE_W-2:0] >= {8'b0, cfg.in_height})
              || iw_reg[ipag_pkg::BASE_W-1]
              || (iw_reg[ipag_pkg::BASE_W-2:0] >= {8'b0, cfg.in_width});

    assign next_row_addr = row_addr_reg + {10'b0, desc_reg.row_step};

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            tap_row_reg   <= '0;
            tap_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            priority if (pop)
            begin
                busy_reg    <= 1'b1;
                tap_row_reg <= '0;
                tap_col_reg <= '0;
            end
            else if (emit && last)
            begin
                busy_reg    <= 1'b0;
                tap_row_reg <= '0;
                tap_col_reg <= '0;
            end
            else if (emit && row_end)
            begin
                tap_col_reg <= '0;
                tap_row_reg <= tap_row_reg + 1'b1;
            end
            else if (emit)
            begin
                tap_col_reg <= tap_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.src_address <= pad ? '0 : addr_reg;
            out_data_reg.dst_address <= dst_reg;
            out_data_reg.is_padding  <= pad;
            out_data_reg.last_tap    <= last;
        end

        priority if (pop)
        begin
            desc_reg     <= pop_data;
            ih_reg       <= pop_data.row_base;
            iw_reg       <= pop_data.col_base;
            row_addr_reg <= pop_data.src_base;
            addr_reg     <= pop_data.src_base;
            dst_reg      <= pop_data.dst_base;
        end
        else if (emit && row_end)
        begin
            ih_reg       <= ih_reg + {14'b0, cfg.rate_row};
            iw_reg       <= desc_reg.col_base;
            row_addr_reg <= next_row_addr;
            addr_reg     <= next_row_addr;
            dst_reg      <= dst_reg + {37'b0, cfg.channels};
        end
        else if (emit)
        begin
            iw_reg   <= iw_reg + {14'b0, cfg.rate_col};
            addr_reg <= addr_reg + {23'b0, desc_reg.col_step};
            dst_reg  <= dst_reg + {37'b0, cfg.channels};
        end
    end

endmodule

// ----- src/image_patch_address_generator_unit.sv -----
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_data   (one output pixel)
// out      out_valid / out_ready  out_data  (one kernel tap)
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// The front unit handles one pixel at a time (accept, five multiply/add steps, queue push).
// The back unit emits one tap per cycle while out_ready allows, kernel_height * kernel_width taps per pixel.
// A two-entry descriptor queue sits between front and back; out_ready low stalls only
// the back, and the front keeps working until the queue fills.
// Reset loads the default configuration and empties the queue and output register.
module image_patch_address_generator_unit #(
    parameter int MAX_KERNEL = 8,
    parameter int MAX_DIM    = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ipag_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ipag_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipag_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ipag_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DIM_FIELD_MAX = (1 << ipag_pkg::CFG_DIM_W) - 1;
    localparam int DIM_LIMIT     = (MAX_DIM > DIM_FIELD_MAX) ? DIM_FIELD_MAX : MAX_DIM;
    localparam logic [ipag_pkg::CFG_DIM_W-1:0] DIM_CAP = ipag_pkg::CFG_DIM_W'(DIM_LIMIT);
    localparam logic [ipag_pkg::CFG_KER_W-1:0] KER_CAP = ipag_pkg::CFG_KER_W'(MAX_KERNEL);

    logic [ipag_pkg::CFG_DIM_W-1:0] in_height_reg, in_width_reg, channels_reg;
    logic [ipag_pkg::CFG_KER_W-1:0] kernel_height_reg, kernel_width_reg;
    logic [15:0]                    stride_pair_reg, dilation_pair_reg, padding_pair_reg;

    ipag_pkg::cfg_t  cfg;
    logic            push, full, pop, empty;
    ipag_pkg::desc_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg     <= 13'd1;
            in_width_reg      <= 13'd1;
            channels_reg      <= 13'd1;
            kernel_height_reg <= 4'd1;
            kernel_width_reg  <= 4'd1;
            stride_pair_reg   <= 16'h0101;
            dilation_pair_reg <= 16'h0101;
            padding_pair_reg  <= 16'h0000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ipag_pkg::CFG_IN_HEIGHT:     in_height_reg     <= cfg_data[12:0];
                ipag_pkg::CFG_IN_WIDTH:      in_width_reg      <= cfg_data[12:0];
                ipag_pkg::CFG_CHANNELS:      channels_reg      <= cfg_data[12:0];
                ipag_pkg::CFG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[3:0];
                ipag_pkg::CFG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[3:0];
                ipag_pkg::CFG_STRIDE_PAIR:   stride_pair_reg   <= cfg_data;
                ipag_pkg::CFG_DILATION_PAIR: dilation_pair_reg <= cfg_data;
                ipag_pkg::CFG_PADDING_PAIR:  padding_pair_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Dimensions saturate; a zero kernel size counts as one
    always_comb
    begin
        cfg.in_height     = (in_height_reg > DIM_CAP) ? DIM_CAP : in_height_reg;
        cfg.in_width      = (in_width_reg > DIM_CAP) ? DIM_CAP : in_width_reg;
        cfg.channels      = (channels_reg > DIM_CAP) ? DIM_CAP : channels_reg;
        cfg.kernel_height = (kernel_height_reg == '0) ? 4'd1 :
                            (kernel_height_reg > KER_CAP) ? KER_CAP : kernel_height_reg;
        cfg.kernel_width  = (kernel_width_reg == '0) ? 4'd1 :
                            (kernel_width_reg > KER_CAP) ? KER_CAP : kernel_width_reg;
        cfg.stride_row    = stride_pair_reg[15:8];
        cfg.stride_col    = stride_pair_reg[7:0];
        cfg.rate_row      = dilation_pair_reg[15:8];
        cfg.rate_col      = dilation_pair_reg[7:0];
        cfg.pad_top       = padding_pair_reg[15:8];
        cfg.pad_left      = padding_pair_reg[7:0];
    end

    ipag_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    ipag_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    ipag_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_KERNEL     = 8;
    localparam int MAX_DIM        = 4096;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PIXELS_PER_SET = 40;
    localparam int RANDOM_SETS    = 12;

    // indexes that map to no register
    localparam logic [ipag_pkg::CFG_INDEX_W-1:0] CFG_NO_REG_LO = 4'd8;
    localparam logic [ipag_pkg::CFG_INDEX_W-1:0] CFG_NO_REG_HI = 4'd15;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    ipag_pkg::in_item_t               in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    ipag_pkg::out_item_t              out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ipag_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ipag_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // shadow copy of the register file, as written
    logic [12:0] sh_height   = 13'd1;
    logic [12:0] sh_width    = 13'd1;
    logic [12:0] sh_channels = 13'd1;
    logic [3:0]  sh_kheight  = 4'd1;
    logic [3:0]  sh_kwidth   = 4'd1;
    logic [15:0] sh_stride   = 16'd257;
    logic [15:0] sh_dilation = 16'd257;
    logic [15:0] sh_padding  = 16'd0;

    ipag_pkg::in_item_t  pixel_queue[$];
    ipag_pkg::out_item_t tap_expect[$];
    ipag_pkg::out_item_t want_tap;

    int   error_count  = 0;
    int   stall_cycles = 0;
    int   hold_left    = 0;
    logic hold_arm     = 1'b0;
    int   src_idle_pct = 16;
    int   snk_idle_pct = 80;

    image_patch_address_generator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint dim_eff(logic [12:0] v);
        if (v > 13'(MAX_DIM))
            return MAX_DIM;
        return longint'(v);
    endfunction

    function automatic longint ker_eff(logic [3:0] v);
        if (v == 4'd0)
            return 1;
        if (v > 4'(MAX_KERNEL))
            return MAX_KERNEL;
        return longint'(v);
    endfunction

    task automatic flag_error(string what);
        $display("%0t ERROR %s", $time, what);
        error_count++;
    endtask

    // expands one output pixel into its kernel taps, row-major
    task automatic expand_pixel(ipag_pkg::in_item_t px);
        longint              hmax, wmax, ch, kh, kw;
        longint              srow, scol, rrow, rcol, ptop, pleft;
        longint              batch, orow, ocol, ih, iw, src, dst, dst_base, tap, r, c;
        ipag_pkg::out_item_t t;
        hmax     = dim_eff(sh_height);
        wmax     = dim_eff(sh_width);
        ch       = dim_eff(sh_channels);
        kh       = ker_eff(sh_kheight);
        kw       = ker_eff(sh_kwidth);
        srow     = sh_stride[15:8];
        scol     = sh_stride[7:0];
        rrow     = sh_dilation[15:8];
        rcol     = sh_dilation[7:0];
        ptop     = sh_padding[15:8];
        pleft    = sh_padding[7:0];
        batch    = px.batch_index;
        orow     = px.out_row;
        ocol     = px.out_col;
        dst_base = longint'(px.out_pixel) * ch * kh * kw;
        for (r = 0; r < kh; r++)
        begin
            ih = orow * srow + r * rrow - ptop;
            for (c = 0; c < kw; c++)
            begin
                iw  = ocol * scol + c * rcol - pleft;
                tap = r * kw + c;
                t.is_padding = (ih < 0 || ih >= hmax || iw < 0 || iw >= wmax);
                src = t.is_padding ? 0 : ((batch * hmax + ih) * wmax + iw) * ch;
                dst = dst_base + tap * ch;
                t.src_address = src[ipag_pkg::SRC_W-1:0];
                t.dst_address = dst[ipag_pkg::DST_W-1:0];
                t.last_tap    = (tap + 1 == kh * kw);
                tap_expect.push_back(t);
            end
        end
    endtask

    // register shadow follows every write transfer
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ipag_pkg::CFG_IN_HEIGHT:     sh_height   = cfg_data[12:0];
                ipag_pkg::CFG_IN_WIDTH:      sh_width    = cfg_data[12:0];
                ipag_pkg::CFG_CHANNELS:      sh_channels = cfg_data[12:0];
                ipag_pkg::CFG_KERNEL_HEIGHT: sh_kheight  = cfg_data[3:0];
                ipag_pkg::CFG_KERNEL_WIDTH:  sh_kwidth   = cfg_data[3:0];
                ipag_pkg::CFG_STRIDE_PAIR:   sh_stride   = cfg_data;
                ipag_pkg::CFG_DILATION_PAIR: sh_dilation = cfg_data;
                ipag_pkg::CFG_PADDING_PAIR:  sh_padding  = cfg_data;
                default: ;
            endcase
        end
    end

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expand_pixel(in_data);
            if (!in_valid || in_ready)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pixel_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // tap monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tap_expect.size() == 0)
                    flag_error("tap transfer with nothing expected");
                else
                begin
                    want_tap = tap_expect.pop_front();
                    if (out_data.src_address !== want_tap.src_address)
                        flag_error($sformatf("src_address got %h want %h",
                                             out_data.src_address, want_tap.src_address));
                    if (out_data.dst_address !== want_tap.dst_address)
                        flag_error($sformatf("dst_address got %h want %h",
                                             out_data.dst_address, want_tap.dst_address));
                    if (out_data.is_padding !== want_tap.is_padding)
                        flag_error($sformatf("is_padding got %b want %b",
                                             out_data.is_padding, want_tap.is_padding));
                    if (out_data.last_tap !== want_tap.last_tap)
                        flag_error($sformatf("last_tap got %b want %b",
                                             out_data.last_tap, want_tap.last_tap));
                end
            end
            if (hold_left > 0)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic write_reg(logic [ipag_pkg::CFG_INDEX_W-1:0] idx,
                             logic [ipag_pkg::CFG_DATA_W-1:0]  value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_unit(logic [15:0] h, logic [15:0] w, logic [15:0] c,
                                logic [15:0] kh, logic [15:0] kw, logic [15:0] st,
                                logic [15:0] dl, logic [15:0] pd);
        write_reg(ipag_pkg::CFG_IN_HEIGHT, h);
        write_reg(ipag_pkg::CFG_IN_WIDTH, w);
        write_reg(ipag_pkg::CFG_CHANNELS, c);
        write_reg(ipag_pkg::CFG_KERNEL_HEIGHT, kh);
        write_reg(ipag_pkg::CFG_KERNEL_WIDTH, kw);
        write_reg(ipag_pkg::CFG_STRIDE_PAIR, st);
        write_reg(ipag_pkg::CFG_DILATION_PAIR, dl);
        write_reg(ipag_pkg::CFG_PADDING_PAIR, pd);
    endtask

    task automatic random_setup();
        logic [15:0] h, w, c, kh, kw, st, dl, pd;
        h  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(24, 1));
        w  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(24, 1));
        c  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(64, 1));
        kh = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4, 1));
        kw = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4, 1));
        st = ($urandom_range(9) == 0) ? 16'($urandom)
             : {8'($urandom_range(3, 1)), 8'($urandom_range(3, 1))};
        dl = ($urandom_range(9) == 0) ? 16'($urandom)
             : {8'($urandom_range(3, 1)), 8'($urandom_range(3, 1))};
        pd = ($urandom_range(9) == 0) ? 16'($urandom)
             : {8'($urandom_range(2)), 8'($urandom_range(2))};
        program_unit(h, w, c, kh, kw, st, dl, pd);
        if ($urandom_range(3) == 0)
            write_reg(CFG_NO_REG_LO + 4'($urandom_range(7)), 16'($urandom));
    endtask

    task automatic queue_pixel(logic [7:0] b, logic [11:0] r, logic [11:0] c,
                               logic [31:0] p);
        ipag_pkg::in_item_t px;
        px.batch_index = b;
        px.out_row     = r;
        px.out_col     = c;
        px.out_pixel   = p;
        pixel_queue.push_back(px);
    endtask

    // mostly pixels whose patch lands on or near the image, some fully random
    task automatic queue_random_pixel();
        ipag_pkg::in_item_t px;
        longint             srow, scol, row_hi, col_hi;
        px.batch_index = 8'($urandom);
        px.out_pixel   = $urandom;
        if ($urandom_range(99) < 15)
        begin
            px.out_row = 12'($urandom);
            px.out_col = 12'($urandom);
        end
        else
        begin
            srow   = (sh_stride[15:8] == 8'd0) ? 1 : sh_stride[15:8];
            scol   = (sh_stride[7:0] == 8'd0) ? 1 : sh_stride[7:0];
            row_hi = dim_eff(sh_height) / srow + 1;
            col_hi = dim_eff(sh_width) / scol + 1;
            if (row_hi > 4095)
                row_hi = 4095;
            if (col_hi > 4095)
                col_hi = 4095;
            px.out_row = 12'($urandom_range(32'(row_hi), 0));
            px.out_col = 12'($urandom_range(32'(col_hi), 0));
        end
        pixel_queue.push_back(px);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || in_valid || tap_expect.size() != 0);
    endtask

    initial
    begin
        int set_no;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: 1x1 image, 1x1 kernel
        @(negedge clk);
        queue_pixel(8'd0, 12'd0, 12'd0, 32'd0);
        queue_pixel(8'd255, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        queue_pixel(8'd0, 12'd1, 12'd0, 32'd5);
        queue_pixel(8'd7, 12'd0, 12'd0, 32'd9);
        wait_drained();

        // 3x3 same padding on a small image; writes to unmapped indexes are dropped
        program_unit(16'd6, 16'd7, 16'd3, 16'd3, 16'd3, 16'h0101, 16'h0101, 16'h0101);
        write_reg(CFG_NO_REG_LO, 16'hFFFF);
        write_reg(CFG_NO_REG_HI, 16'h0000);
        @(negedge clk);
        queue_pixel(8'd0, 12'd0, 12'd0, 32'd0);
        queue_pixel(8'd1, 12'd5, 12'd6, 32'd41);
        queue_pixel(8'd2, 12'd2, 12'd3, 32'd100);
        queue_pixel(8'd255, 12'd4095, 12'd0, 32'hFFFF_FFFF);
        wait_drained();

        // zero height, zero channels, zero kernel, zero stride, oversized width
        program_unit(16'hE000, 16'hFFFF, 16'd0, 16'd0, 16'hFFF0, 16'h0000,
                     16'hFFFF, 16'h0000);
        @(negedge clk);
        queue_pixel(8'd3, 12'd10, 12'd10, 32'd7);
        queue_pixel(8'd255, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        wait_drained();

        // every size saturated, widest kernel, addresses wrap
        program_unit(16'h1FFF, 16'd4097, 16'h1FFF, 16'd9, 16'd15, 16'hFFFF,
                     16'hFFFF, 16'hFFFF);
        @(negedge clk);
        queue_pixel(8'd255, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        queue_pixel(8'd255, 12'd16, 12'd16, 32'd123456);
        queue_pixel(8'd0, 12'd0, 12'd0, 32'd0);
        wait_drained();

        // row stride 0 and column rate 0
        program_unit(16'd5, 16'd5, 16'd2, 16'd8, 16'd1, 16'h0002, 16'h0300, 16'h0003);
        @(negedge clk);
        queue_pixel(8'd0, 12'd3, 12'd1, 32'd12);
        queue_pixel(8'd1, 12'd0, 12'd2, 32'd0);
        wait_drained();

        for (set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            if (set_no == 3)
            begin
                src_idle_pct <= 80;
                snk_idle_pct <= 16;
            end
            if (set_no == 8)
            begin
                src_idle_pct <= 0;
                snk_idle_pct <= 0;
            end
            random_setup();
            if (set_no == 8)
            begin
                // receiver stalls while pixels keep coming, backs up the queue
                hold_arm <= 1'b1;
                @(posedge clk);
                hold_arm <= 1'b0;
            end
            @(negedge clk);
            repeat (PIXELS_PER_SET) queue_random_pixel();
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (error_count == 0 && tap_expect.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
